>>> rtl/core/u8dc_pkg.sv
// ----------------------------------------------------------------------------
// u8dc_pkg
// Shared types, lead byte classes and the CP1252 C1 table for the decoder.
// ----------------------------------------------------------------------------
package u8dc_pkg;

  typedef struct packed {
    logic [47:0] window_bytes;
    logic [2:0]  bytes_present;
  } in_t;

  typedef struct packed {
    logic [30:0] code_point;
    logic [2:0]  bytes_used;
    logic        fell_back;
  } out_t;

  // Lead byte classes; for a good lead the sequence length is class + 1
  localparam logic [2:0] CLS_ASCII = 3'd0;
  localparam logic [2:0] CLS_TWO   = 3'd1;
  localparam logic [2:0] CLS_THREE = 3'd2;
  localparam logic [2:0] CLS_FOUR  = 3'd3;
  localparam logic [2:0] CLS_FIVE  = 3'd4;
  localparam logic [2:0] CLS_SIX   = 3'd5;
  localparam logic [2:0] CLS_BAD   = 3'd6;

  // Stage one result for one window
  typedef struct packed {
    logic [2:0] lead_cls;
    logic       cont_ok;
    logic       pair_tail_ok;
  } cls_t;

  function automatic logic [15:0] cp1252_c1(input logic [4:0] idx);
    logic [15:0] r;
    case (idx)
      5'd0:  r = 16'h20AC;  5'd1:  r = 16'h278A;  5'd2:  r = 16'h201A;
      5'd3:  r = 16'h0192;  5'd4:  r = 16'h201E;  5'd5:  r = 16'h2026;
      5'd6:  r = 16'h2020;  5'd7:  r = 16'h2021;  5'd8:  r = 16'h02C6;
      5'd9:  r = 16'h2030;  5'd10: r = 16'h0160;  5'd11: r = 16'h2039;
      5'd12: r = 16'h0152;  5'd13: r = 16'h278B;  5'd14: r = 16'h017D;
      5'd15: r = 16'h278C;  5'd16: r = 16'h278D;  5'd17: r = 16'h2018;
      5'd18: r = 16'h2019;  5'd19: r = 16'h201C;  5'd20: r = 16'h201D;
      5'd21: r = 16'h2022;  5'd22: r = 16'h2013;  5'd23: r = 16'h2014;
      5'd24: r = 16'h02DC;  5'd25: r = 16'h2122;  5'd26: r = 16'h0161;
      5'd27: r = 16'h203A;  5'd28: r = 16'h0153;  5'd29: r = 16'h278E;
      5'd30: r = 16'h017E;  default: r = 16'h0178;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/u8dc_classify.sv
// ----------------------------------------------------------------------------
// u8dc_classify
// Lead byte class, continuation checks and CESU-8 low half check of a window.
// ----------------------------------------------------------------------------
module u8dc_classify
  import u8dc_pkg::*;
(
  input  in_t  win,
  output cls_t cls
);

  logic [7:0] b0;
  logic [2:0] pres_eff;
  logic [5:1] cont;
  logic [5:1] need;
  logic [2:0] lead_cls;

  always_comb begin
    b0       = win.window_bytes[7:0];
    pres_eff = (win.bytes_present == 3'd7) ? 3'd6 : win.bytes_present;
    for (int i = 1; i < 6; i++) begin
      cont[i] = (i < int'(pres_eff)) && (win.window_bytes[8*i+6 +: 2] == 2'b10);
    end

    if (b0 < 8'h80)      lead_cls = CLS_ASCII;
    else if (b0 < 8'hC2) lead_cls = CLS_BAD;
    else if (b0 < 8'hE0) lead_cls = CLS_TWO;
    else if (b0 < 8'hF0) lead_cls = CLS_THREE;
    else if (b0 < 8'hF8) lead_cls = CLS_FOUR;
    else if (b0 < 8'hFC) lead_cls = CLS_FIVE;
    else if (b0 < 8'hFE) lead_cls = CLS_SIX;
    else                 lead_cls = CLS_BAD;

    unique case (lead_cls)
      CLS_TWO:   need = 5'b00001;
      CLS_THREE: need = 5'b00011;
      CLS_FOUR:  need = 5'b00111;
      CLS_FIVE:  need = 5'b01111;
      CLS_SIX:   need = 5'b11111;
      default:   need = 5'b00000;
    endcase

    cls.lead_cls     = lead_cls;
    cls.cont_ok      = &(cont[5:1] | ~need);
    // low surrogate ED B0..BF xx in bytes 3..5
    cls.pair_tail_ok = (win.window_bytes[31:24] == 8'hED) && cont[4] && cont[5]
                       && (win.window_bytes[39:36] == 4'hB);
  end

endmodule

>>> rtl/core/utf8_decoder_cp1252_fallback_top.sv
// ----------------------------------------------------------------------------
// utf8_decoder_cp1252_fallback_top
// Four stage UTF-8 character decoder with Latin-1 / CP1252 fallback.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: a six-byte window starting at a character boundary plus the
//   count of real bytes in it. Output beat: the first character's code point,
//   the bytes it consumed and a flag set when the first byte was taken as
//   Latin-1. The caller advances its stream by bytes_used.
//   cfg_wr_en/cfg_wr_data write ansi_fix; write it only while the block is
//   empty.
//   An accepted input beat reaches out_valid through classify, assemble,
//   validate and CP1252 map, the last into the output register.
//   Throughput: one beat per cycle unless stalled; each stage holds one beat
//   and the stages are set by the byte classify, field assemble and map logic.
//   Reset (synchronous, rst_n low) empties the pipeline and clears ansi_fix.
//   When out_stall holds, the output beat holds and stages behind it fill
//   their bubbles; in_stall rises only once every stage is occupied.
// ----------------------------------------------------------------------------
module utf8_decoder_cp1252_fallback_top
  import u8dc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_wr_en,
  input  logic cfg_wr_data,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic ansi_fix_r;

  // stage 1
  logic        s1_valid_r;
  logic [47:0] s1_win_r;
  cls_t        s1_cls_r;
  cls_t        cls_nxt;
  // stage 2
  logic        s2_valid_r;
  logic [30:0] s2_val_r;
  logic        s2_seq_ok_r;
  logic [2:0]  s2_cls_r;
  logic        s2_pair_ok_r;
  logic [7:0]  s2_b0_r;
  logic [9:0]  s2_w10_r;
  logic [30:0] val_nxt;
  logic        ovl_nxt;
  // stage 3
  logic        s3_valid_r;
  logic [30:0] s3_code_r;
  logic [2:0]  s3_len_r;
  logic        s3_fell_r;
  logic [30:0] code_nxt;
  logic [2:0]  len_nxt;
  logic        ok_nxt;
  logic        hi_sur;
  logic        lo_sur;
  logic [20:0] pair_sum;
  // stage 4
  logic        out_valid_r;
  out_t        out_data_r;
  out_t        out_nxt;
  logic        go1, go2, go3, go4;

  // a stage takes a beat when it is empty or its beat moves on
  assign go4      = !out_valid_r || !out_stall;
  assign go3      = !s3_valid_r || go4;
  assign go2      = !s2_valid_r || go3;
  assign go1      = !s1_valid_r || go2;
  assign in_stall = !go1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ansi_fix_r <= 1'b0;
    end else if (cfg_wr_en) begin
      ansi_fix_r <= cfg_wr_data;
    end
  end

  u8dc_classify u_classify (
    .win (in_data),
    .cls (cls_nxt)
  );

  // assemble the sequence value and check for overlong forms
  always_comb begin
    val_nxt = 31'd0;
    ovl_nxt = 1'b0;
    unique case (s1_cls_r.lead_cls)
      CLS_TWO: begin
        val_nxt = 31'({s1_win_r[4:0], s1_win_r[13:8]});
      end
      CLS_THREE: begin
        val_nxt = 31'({s1_win_r[3:0], s1_win_r[13:8], s1_win_r[21:16]});
        ovl_nxt = (val_nxt[15:11] == 5'd0);
      end
      CLS_FOUR: begin
        val_nxt = 31'({s1_win_r[2:0], s1_win_r[13:8], s1_win_r[21:16],
                       s1_win_r[29:24]});
        ovl_nxt = (val_nxt[20:16] == 5'd0);
      end
      CLS_FIVE: begin
        val_nxt = 31'({s1_win_r[1:0], s1_win_r[13:8], s1_win_r[21:16],
                       s1_win_r[29:24], s1_win_r[37:32]});
        ovl_nxt = (val_nxt[25:21] == 5'd0);
      end
      CLS_SIX: begin
        val_nxt = {s1_win_r[0], s1_win_r[13:8], s1_win_r[21:16],
                   s1_win_r[29:24], s1_win_r[37:32], s1_win_r[45:40]};
        ovl_nxt = (val_nxt[30:26] == 5'd0);
      end
      default: begin
        val_nxt = 31'(s1_win_r[7:0]);
      end
    endcase
  end

  // surrogate and noncharacter checks, pair combine, fallback select
  always_comb begin
    hi_sur   = (s2_cls_r == CLS_THREE) && (s2_val_r[15:10] == 6'b110110);
    lo_sur   = (s2_cls_r == CLS_THREE) && (s2_val_r[15:10] == 6'b110111);
    pair_sum = 21'h10000 + 21'({s2_val_r[9:0], s2_w10_r});
    ok_nxt   = s2_seq_ok_r && !lo_sur && !(hi_sur && !s2_pair_ok_r)
               && (s2_val_r != 31'h0000FFFE) && (s2_val_r != 31'h0000FFFF);
    if (!ok_nxt) begin
      code_nxt = 31'(s2_b0_r);
      len_nxt  = 3'd1;
    end else if (hi_sur) begin
      code_nxt = 31'(pair_sum);
      len_nxt  = 3'd6;
    end else begin
      code_nxt = s2_val_r;
      len_nxt  = s2_cls_r + 3'd1;
    end
  end

  // C1 range maps through CP1252 on fallback, or always with ansi_fix
  always_comb begin
    out_nxt.code_point = s3_code_r;
    out_nxt.bytes_used = s3_len_r;
    out_nxt.fell_back  = s3_fell_r;
    if ((s3_code_r[30:5] == 26'h4) && (s3_fell_r || ansi_fix_r)) begin
      out_nxt.code_point = 31'(cp1252_c1(s3_code_r[4:0]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (go1) s1_valid_r  <= in_valid;
      if (go2) s2_valid_r  <= s1_valid_r;
      if (go3) s3_valid_r  <= s2_valid_r;
      if (go4) out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (go1) begin
      s1_win_r <= in_data.window_bytes;
      s1_cls_r <= cls_nxt;
    end
    if (go2) begin
      s2_val_r     <= val_nxt;
      s2_seq_ok_r  <= (s1_cls_r.lead_cls != CLS_BAD) && s1_cls_r.cont_ok && !ovl_nxt;
      s2_cls_r     <= s1_cls_r.lead_cls;
      s2_pair_ok_r <= s1_cls_r.pair_tail_ok;
      s2_b0_r      <= s1_win_r[7:0];
      s2_w10_r     <= {s1_win_r[35:32], s1_win_r[45:40]};
    end
    if (go3) begin
      s3_code_r <= code_nxt;
      s3_len_r  <= len_nxt;
      s3_fell_r <= !ok_nxt;
    end
    if (go4) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/core/u8dc_checker.sv
// ----------------------------------------------------------------------------
// u8dc_checker
// Port-level checks on the decoder's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module u8dc_checker
  import u8dc_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // hold a stalled beat
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_fallback_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.fell_back |-> out_data.bytes_used == 3'd1)
    else $error("fallback consumed more than one byte");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.bytes_used != 3'd0 && out_data.bytes_used != 3'd7)
    else $error("bytes_used out of range");

  // a good one-byte character is plain ASCII
  a_ascii: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.fell_back && out_data.bytes_used == 3'd1
      |-> out_data.code_point < 31'h80)
    else $error("one-byte character above ASCII");

endmodule

bind utf8_decoder_cp1252_fallback_top u8dc_checker u_u8dc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> verif/tb_utf8_decoder_cp1252_fallback_top.sv
// ----------------------------------------------------------------------------
// tb_utf8_decoder_cp1252_fallback_top
// Self-checking bench for the UTF-8 decoder with Latin-1 / CP1252 fallback.
// A short stimulus table hits the edges: byte counts, bad leads, overlong
// forms, the noncharacters, surrogates and CESU-8 pairs, and C1 values with
// and without ansi_fix. A random text stream follows. Each beat is checked
// against the table or a local model. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_utf8_decoder_cp1252_fallback_top
  import u8dc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PIPE_LAT    = 4;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_BEATS = 125;
  localparam int unsigned IDLE_PCT    = 38;

  // CP1252 glyphs for the C1 range 0x80..0x9F
  localparam bit [15:0] C1_GLYPH [32] = '{
    16'h20AC, 16'h278A, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
    16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h278B, 16'h017D, 16'h278C,
    16'h278D, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
    16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h278E, 16'h017E, 16'h0178
  };

  localparam bit [31:0] SURR_HI_FIRST = 32'hD800;
  localparam bit [31:0] SURR_HI_LAST  = 32'hDBFF;
  localparam bit [31:0] SURR_LO_FIRST = 32'hDC00;
  localparam bit [31:0] SURR_LO_LAST  = 32'hDFFF;
  localparam bit [31:0] NONCHAR_FFFE  = 32'hFFFE;
  localparam bit [31:0] NONCHAR_FFFF  = 32'hFFFF;
  localparam bit [31:0] CP_MAX        = 32'h7FFFFFFF;
  localparam bit [31:0] SUPP_BASE     = 32'h10000;

  typedef struct packed {
    bit [47:0] win;
    bit [2:0]  cnt;
    bit        fix;
    bit        typed;
    bit [30:0] cp;
    bit [2:0]  used;
    bit        fb;
  } script_row_t;

  localparam int unsigned N_ROWS = 25;
  localparam script_row_t SCRIPT [N_ROWS] = '{
    '{48'h000000000041, 3'd1, 1'b0, 1'b1, 31'h41,     3'd1, 1'b0},
    '{48'h000000000000, 3'd0, 1'b0, 1'b1, 31'h0,      3'd1, 1'b0},
    '{48'hFFFFFFFFFF7F, 3'd7, 1'b0, 1'b1, 31'h7F,     3'd1, 1'b0},
    '{48'hFFFFFFFFFFFF, 3'd6, 1'b0, 1'b1, 31'hFF,     3'd1, 1'b1},
    '{48'h000000000080, 3'd1, 1'b0, 1'b1, 31'h20AC,   3'd1, 1'b1},
    '{48'h00000000009F, 3'd1, 1'b0, 1'b1, 31'h0178,   3'd1, 1'b1},
    '{48'h00000000BFC1, 3'd2, 1'b0, 1'b1, 31'hC1,     3'd1, 1'b1},
    '{48'h0000000000FE, 3'd1, 1'b0, 1'b1, 31'hFE,     3'd1, 1'b1},
    '{48'h0000000080C2, 3'd2, 1'b0, 1'b1, 31'h80,     3'd2, 1'b0},
    '{48'h0000000080C2, 3'd1, 1'b0, 1'b1, 31'hC2,     3'd1, 1'b1},
    '{48'h0000008080E0, 3'd3, 1'b0, 1'b1, 31'hE0,     3'd1, 1'b1},
    '{48'h000000BEBFEF, 3'd3, 1'b0, 1'b1, 31'hEF,     3'd1, 1'b1},
    '{48'h000000BFBFEF, 3'd3, 1'b0, 1'b1, 31'hEF,     3'd1, 1'b1},
    '{48'h000000BDBFEF, 3'd3, 1'b0, 1'b1, 31'hFFFD,   3'd3, 1'b0},
    '{48'h00000080B0ED, 3'd3, 1'b0, 1'b1, 31'hED,     3'd1, 1'b1},
    '{48'h00000080A0ED, 3'd3, 1'b0, 1'b1, 31'hED,     3'd1, 1'b1},
    '{48'h80B0ED80A0ED, 3'd6, 1'b0, 1'b1, 31'h10000,  3'd6, 1'b0},
    '{48'hBFBFEDBFAFED, 3'd6, 1'b0, 1'b1, 31'h10FFFF, 3'd6, 1'b0},
    '{48'h00004180A0ED, 3'd4, 1'b0, 1'b0, 31'h0,      3'd0, 1'b0},
    '{48'h0000BFBF8FF4, 3'd4, 1'b0, 1'b0, 31'h0,      3'd0, 1'b0},
    '{48'h8080808084FC, 3'd6, 1'b0, 1'b0, 31'h0,      3'd0, 1'b0},
    '{48'hBFBFBFBF83FC, 3'd6, 1'b0, 1'b0, 31'h0,      3'd0, 1'b0},
    '{48'hBFBFBFBFBFFD, 3'd6, 1'b0, 1'b1, 31'h7FFFFFFF, 3'd6, 1'b0},
    '{48'h0000000080C2, 3'd2, 1'b1, 1'b1, 31'h20AC,   3'd2, 1'b0},
    '{48'h0000000081C2, 3'd6, 1'b1, 1'b0, 31'h0,      3'd0, 1'b0}
  };

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic cfg_wr_en   = 1'b0;
  logic cfg_wr_data = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  out_t        chars_due [$];
  out_t        oldest;
  bit          fix_now = 1'b0;
  bit          calm = 1'b0;
  int unsigned bad_chars = 0;
  int unsigned cycles = 0;

  utf8_decoder_cp1252_fallback_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------- model

  function automatic bit [31:0] byte_at(bit [47:0] w, int unsigned i);
    if (i >= 6) return 32'h0;
    return 32'(w[8*i +: 8]);
  endfunction

  function automatic bit is_follow(bit [47:0] w, int unsigned cnt, int unsigned i);
    if (i >= 6 || i >= cnt) return 1'b0;
    return w[8*i+6 +: 2] == 2'b10;
  endfunction

  // Decode one plain sequence starting at byte 'at'
  function automatic bit [31:0] scan_seq(bit [47:0] w, int unsigned cnt, int unsigned at,
                                         output int unsigned n_used, output bit good);
    bit [31:0] lead;
    bit [31:0] v;
    int unsigned n;
    int unsigned k;
    int unsigned rem;
    lead = byte_at(w, at);
    good = 1'b1;
    n_used = 1;
    if (lead < 32'h80) return lead;
    if (lead < 32'hC2 || lead >= 32'hFE) begin
      good = 1'b0;
      return lead;
    end
    if (lead < 32'hE0) begin
      n = 1; v = (lead & 32'h1F) << 6;
    end else if (lead < 32'hF0) begin
      n = 2; v = (lead & 32'h0F) << 12;
    end else if (lead < 32'hF8) begin
      n = 3; v = (lead & 32'h07) << 18;
    end else if (lead < 32'hFC) begin
      n = 4; v = (lead & 32'h03) << 24;
    end else begin
      n = 5; v = (lead & 32'h01) << 30;
    end
    for (k = 1; k <= n; k++) begin
      rem = n - k;
      if (!is_follow(w, cnt, at + k)) good = 1'b0;
      v |= (byte_at(w, at + k) & 32'h3F) << (6 * rem);
      // reject overlong as soon as the value so far is too small
      if (rem > 0 && v < (32'd1 << (5 * rem + 6))) good = 1'b0;
    end
    n_used = n + 1;
    return v;
  endfunction

  function automatic out_t decode_char(in_t d, bit c1_remap);
    bit [47:0]   w;
    int unsigned cnt;
    int unsigned len;
    int unsigned len2;
    bit          ok;
    bit          ok2;
    bit [31:0]   v;
    bit [31:0]   low_half;
    out_t        r;
    w   = d.window_bytes;
    cnt = d.bytes_present;
    if (cnt > 6) cnt = 6;
    v = scan_seq(w, cnt, 0, len, ok);
    if (ok && v >= SURR_LO_FIRST && v <= SURR_LO_LAST) ok = 1'b0;
    if (ok && v >= SURR_HI_FIRST && v <= SURR_HI_LAST) begin
      low_half = scan_seq(w, cnt, len, len2, ok2);
      if (ok2 && low_half >= SURR_LO_FIRST && low_half <= SURR_LO_LAST) begin
        v = SUPP_BASE + ((v & 32'h3FF) << 10) + (low_half & 32'h3FF);
        len += len2;
      end else begin
        ok = 1'b0;
      end
    end
    if (v == NONCHAR_FFFE || v == NONCHAR_FFFF || v > CP_MAX) ok = 1'b0;
    if (!ok) begin
      v   = byte_at(w, 0);
      len = 1;
    end
    if (v >= 32'h80 && v < 32'hA0 && (!ok || c1_remap)) v = 32'(C1_GLYPH[v - 32'h80]);
    r.code_point = v[30:0];
    r.bytes_used = 3'(len);
    r.fell_back  = !ok;
    return r;
  endfunction

  // ------------------------------------------------------------ generator

  function automatic bit [31:0] seq_floor(int unsigned n);
    case (n)
      2:       return 32'h80;
      3:       return 32'h800;
      4:       return 32'h10000;
      5:       return 32'h200000;
      6:       return 32'h4000000;
      default: return 32'h80000000;
    endcase
  endfunction

  function automatic bit [47:0] put_seq(bit [47:0] w, int unsigned at, bit [31:0] cp,
                                        int unsigned n);
    bit [7:0]    mark;
    int unsigned k;
    case (n)
      2:       mark = 8'hC0;
      3:       mark = 8'hE0;
      4:       mark = 8'hF0;
      5:       mark = 8'hF8;
      default: mark = 8'hFC;
    endcase
    w[8*at +: 8] = mark | 8'(cp >> (6 * (n - 1)));
    for (k = 1; k < n; k++)
      w[8*(at+k) +: 8] = 8'h80 | (8'(cp >> (6 * (n - 1 - k))) & 8'h3F);
    return w;
  endfunction

  function automatic in_t draw_window();
    in_t         d;
    bit [47:0]   w;
    bit [31:0]   cp;
    int unsigned n;
    int unsigned pick;
    int unsigned pos;
    w = {16'($urandom), $urandom};
    d.bytes_present = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd6;
    pick = $urandom_range(0, 99);
    n    = $urandom_range(2, 6);
    cp   = $urandom_range(seq_floor(n), seq_floor(n + 1) - 1);
    if (pick < 15) begin
      w[7:0] = 8'($urandom_range(0, 127));
    end else if (pick < 40) begin
      w = put_seq(w, 0, cp, n);
    end else if (pick < 50) begin
      w = put_seq(w, 0, $urandom_range(SURR_HI_FIRST, SURR_HI_LAST), 3);
      w = put_seq(w, 3, $urandom_range(SURR_LO_FIRST, SURR_LO_LAST), 3);
    end else if (pick < 60) begin
      // hover around the surrogate block and the noncharacters
      cp = $urandom_range(0, 1) ? $urandom_range(32'hD7F8, 32'hE007)
                                : $urandom_range(32'hFFF8, 32'hFFFF);
      w = put_seq(w, 0, cp, 3);
    end else if (pick < 68) begin
      w = put_seq(w, 0, $urandom_range(32'h80, 32'h9F), 2);
    end else if (pick < 85) begin
      w = put_seq(w, 0, cp, n);
      case ($urandom_range(0, 3))
        0: begin
          pos = $urandom_range(1, n - 1);
          w[8*pos +: 8] = 8'($urandom);
        end
        1: d.bytes_present = 3'($urandom_range(0, n - 1));
        2: w = put_seq(w, 0, $urandom_range(0, seq_floor(n) - 1), n);
        default: begin
          // high half with a doubtful low half
          w = put_seq(w, 0, $urandom_range(SURR_HI_FIRST, SURR_HI_LAST), 3);
          w = put_seq(w, 3, $urandom_range(32'hD000, 32'hFFFF), 3);
          pos = $urandom_range(3, 5);
          if ($urandom_range(0, 1) == 1) w[8*pos +: 8] = 8'($urandom);
        end
      endcase
    end else begin
      d.bytes_present = 3'($urandom_range(0, 7));
    end
    d.window_bytes = w;
    return d;
  endfunction

  // --------------------------------------------------------------- driving

  task automatic send_beat(input in_t d, input bit typed, input out_t want);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (in_stall);
    chars_due.push_back(typed ? want : decode_char(d, fix_now));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (chars_due.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  task automatic set_ansi_fix(input bit v);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    fix_now = v;
  endtask

  // -------------------------------------------------------------- checking

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    if (rst_n && out_valid && !out_stall) begin
      if (chars_due.size() == 0) begin
        if (bad_chars < 10)
          $display("unexpected beat: cp=%h used=%0d fb=%0b",
                   out_data.code_point, out_data.bytes_used, out_data.fell_back);
        bad_chars++;
      end else begin
        oldest = chars_due.pop_front();
        if (out_data.code_point !== oldest.code_point ||
            out_data.bytes_used !== oldest.bytes_used ||
            out_data.fell_back  !== oldest.fell_back) begin
          if (bad_chars < 10)
            $display("mismatch: expected cp=%h used=%0d fb=%0b, got cp=%h used=%0d fb=%0b",
                     oldest.code_point, oldest.bytes_used, oldest.fell_back,
                     out_data.code_point, out_data.bytes_used, out_data.fell_back);
          bad_chars++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // -------------------------------------------------------------- sequence

  initial begin
    int unsigned ph;
    int unsigned i;
    in_t         beat;
    out_t        typed_out;
    bit          phase_fix [4];
    phase_fix = '{1'b0, 1'b1, 1'b0, 1'b1};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (SCRIPT[r]) begin
      if (SCRIPT[r].fix != fix_now) set_ansi_fix(SCRIPT[r].fix);
      beat.window_bytes    = SCRIPT[r].win;
      beat.bytes_present   = SCRIPT[r].cnt;
      typed_out.code_point = SCRIPT[r].cp;
      typed_out.bytes_used = SCRIPT[r].used;
      typed_out.fell_back  = SCRIPT[r].fb;
      send_beat(beat, SCRIPT[r].typed, typed_out);
    end

    for (ph = 0; ph < 4; ph++) begin
      set_ansi_fix(phase_fix[ph]);
      for (i = 0; i < PHASE_BEATS; i++) begin
        // hold off until the pipe is empty once, mid stream
        if (ph == 0 && i == 60) wait_drained();
        if (ph == 2 && i == 30) calm <= 1'b1;
        if (ph == 2 && i == 90) calm <= 1'b0;
        send_beat(draw_window(), 1'b0, '0);
      end
    end

    wait_drained();
    if (bad_chars == 0 && chars_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
